// ===== rtl/core/tsdf_pkg.sv =====
// tsdf_pkg: types, codes and constants shared by the telnet stream deframer
// used by tsdf_parser, tsdf_emitter and telnet_stream_deframer_top
`timescale 1ns / 1ps
`default_nettype none

package tsdf_pkg;

    // telnet command bytes
    localparam logic [7:0] TN_IAC  = 8'd255;
    localparam logic [7:0] TN_DONT = 8'd254;
    localparam logic [7:0] TN_DO   = 8'd253;
    localparam logic [7:0] TN_WONT = 8'd252;
    localparam logic [7:0] TN_WILL = 8'd251;
    localparam logic [7:0] TN_SB   = 8'd250;
    localparam logic [7:0] TN_GA   = 8'd249;
    localparam logic [7:0] TN_SE   = 8'd240;
    localparam logic [7:0] TN_EOR  = 8'd239;

    // option codes
    localparam logic [7:0] OPT_BINARY  = 8'd0;
    localparam logic [7:0] OPT_SGA     = 8'd3;
    localparam logic [7:0] OPT_TTYPE   = 8'd24;
    localparam logic [7:0] OPT_EOR     = 8'd25;
    localparam logic [7:0] OPT_NAWS    = 8'd31;
    localparam logic [7:0] OPT_CHARSET = 8'd42;
    localparam logic [7:0] OPT_GMCP    = 8'd201;

    // subnegotiation codes
    localparam logic [7:0] SUB_REQUEST  = 8'd1;
    localparam logic [7:0] SUB_SEND     = 8'd1;
    localparam logic [7:0] SUB_ACCEPTED = 8'd2;

    // plain characters
    localparam logic [7:0] CH_NUL = 8'd0;
    localparam logic [7:0] CH_LF  = 8'd10;
    localparam logic [7:0] CH_CR  = 8'd13;

    localparam int unsigned TOKEN_LEN = 5;

    typedef enum logic [3:0] {
        KIND_DATA      = 4'd0,
        KIND_LINE_END  = 4'd1,
        KIND_PROMPT    = 4'd2,
        KIND_REPLY     = 4'd3,
        KIND_GMCP_BYTE = 4'd4,
        KIND_GMCP_END  = 4'd5,
        KIND_NAWS      = 4'd6,
        KIND_GMCP_HELLO = 4'd7,
        KIND_TTYPE     = 4'd8,
        KIND_UTF8      = 4'd9
    } t_kind;

    typedef enum logic [1:0] {
        MODE_ONE     = 2'd0,
        MODE_REPLY   = 2'd1,
        MODE_CHARSET = 2'd2
    } t_mode;

    // one accepted byte's results, described compactly
    typedef struct packed {
        logic                        valid;
        t_mode                       mode;
        t_kind                       kind;   // single word kind, or trailing event of a reply
        logic                        tail;   // reply carries a trailing event
        logic [7:0]                  value;  // single word byte, or reply option
        logic [7:0]                  cmd;    // reply command byte
        logic [TOKEN_LEN-1:0][7:0]   spell;  // charset name as received
    } t_burst;

    // uppercase spelling of the charset name, one letter per position
    function automatic logic [7:0] utf8_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = 8'h55;
            3'd1:    ch = 8'h54;
            3'd2:    ch = 8'h46;
            3'd3:    ch = 8'h2d;
            3'd4:    ch = 8'h38;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tsdf_parser.sv =====
// tsdf_parser: telnet parse state, negotiation and charset matching
// depends on tsdf_pkg; hands one result descriptor per accepted word to tsdf_emitter
`timescale 1ns / 1ps
`default_nettype none

module tsdf_parser
    import tsdf_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_take,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_restart,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_data,
    output t_burst          o_burst
);

    typedef enum logic [13:0] {
        ST_NORMAL   = 14'b00000000000001,
        ST_IAC      = 14'b00000000000010,
        ST_WILL     = 14'b00000000000100,
        ST_DO       = 14'b00000000001000,
        ST_NEG_SKIP = 14'b00000000010000,
        ST_SB       = 14'b00000000100000,
        ST_SB_SKIP  = 14'b00000001000000,
        ST_SB_IAC   = 14'b00000010000000,
        ST_GMCP     = 14'b00000100000000,
        ST_GMCP_IAC = 14'b00001000000000,
        ST_CS       = 14'b00010000000000,
        ST_CS_LIST  = 14'b00100000000000,
        ST_CS_IAC   = 14'b01000000000000,
        ST_TTYPE    = 14'b10000000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_accept;
    logic   r_naws, n_naws;
    logic   r_line, n_line;
    logic   r_have_sep, n_have_sep;
    logic   [2:0] r_tpos, n_tpos;
    logic   r_tmatch, n_tmatch;
    logic   r_found, n_found;
    logic   [7:0] r_sep, n_sep;
    logic   [TOKEN_LEN-1:0][7:0] r_tspell, n_tspell;
    logic   [TOKEN_LEN-1:0][7:0] r_fspell, n_fspell;

    logic   [7:0] c;
    logic   [7:0] upper;
    logic   close_hit;
    t_burst b;

    assign c         = i_byte;
    assign upper     = (c >= 8'h61 && c <= 8'h7a) ? (c - 8'd32) : c;
    assign close_hit = r_tmatch && (r_tpos == 3'(TOKEN_LEN)) && !r_found && r_accept;

    always_comb begin
        n_state    = r_state;
        n_naws     = r_naws;
        n_line     = r_line;
        n_have_sep = r_have_sep;
        n_tpos     = r_tpos;
        n_tmatch   = r_tmatch;
        n_found    = r_found;
        n_sep      = r_sep;
        n_tspell   = r_tspell;
        n_fspell   = r_fspell;
        b          = '0;
        b.mode     = MODE_ONE;
        b.kind     = KIND_DATA;
        b.spell    = r_fspell;

        if (i_restart) begin
            n_state = ST_NORMAL;
            n_line  = 1'b0;
        end else begin
            case (r_state)
                ST_NORMAL: begin
                    if (c == CH_NUL || c == CH_CR) begin
                        n_state = ST_NORMAL;
                    end else if (c == TN_IAC) begin
                        n_state = ST_IAC;
                    end else if (c == CH_LF) begin
                        b.valid = 1'b1;
                        b.kind  = KIND_LINE_END;
                        n_line  = 1'b0;
                    end else begin
                        b.valid = 1'b1;
                        b.kind  = KIND_DATA;
                        b.value = c;
                        n_line  = 1'b1;
                    end
                end
                ST_IAC: begin
                    n_state = ST_NORMAL;
                    if (c == TN_GA || c == TN_EOR) begin
                        b.valid = r_line;
                        b.kind  = KIND_PROMPT;
                    end else if (c == TN_DONT || c == TN_WONT) begin
                        n_state = ST_NEG_SKIP;
                    end else if (c == TN_DO) begin
                        n_state = ST_DO;
                    end else if (c == TN_WILL) begin
                        n_state = ST_WILL;
                    end else if (c == TN_IAC) begin
                        b.valid = 1'b1;
                        b.kind  = KIND_DATA;
                        b.value = TN_IAC;
                        n_line  = 1'b1;
                    end else if (c == TN_SB) begin
                        n_state = ST_SB;
                    end
                end
                ST_WILL: begin
                    n_state = ST_NORMAL;
                    b.mode  = MODE_REPLY;
                    b.value = c;
                    if (c == OPT_BINARY || c == OPT_CHARSET || c == OPT_EOR) begin
                        b.valid = 1'b1;
                        b.cmd   = TN_DO;
                    end else if (c == OPT_SGA) begin
                        b.valid = 1'b1;
                        b.cmd   = TN_DONT;
                    end else if (c == OPT_GMCP) begin
                        b.valid = 1'b1;
                        b.cmd   = TN_DO;
                        b.tail  = 1'b1;
                        b.kind  = KIND_GMCP_HELLO;
                    end
                end
                ST_DO: begin
                    n_state = ST_NORMAL;
                    b.mode  = MODE_REPLY;
                    b.value = c;
                    if (c == OPT_BINARY || c == OPT_CHARSET || c == OPT_TTYPE) begin
                        b.valid = 1'b1;
                        b.cmd   = TN_WILL;
                    end else if (c == OPT_NAWS) begin
                        if (!r_naws) begin
                            n_naws  = 1'b1;
                            b.valid = 1'b1;
                            b.cmd   = TN_WILL;
                            b.tail  = 1'b1;
                            b.kind  = KIND_NAWS;
                        end
                    end else begin
                        b.valid = 1'b1;
                        b.cmd   = TN_WONT;
                    end
                end
                ST_NEG_SKIP: begin
                    n_state = ST_NORMAL;
                end
                ST_SB: begin
                    if (c == OPT_CHARSET) begin
                        n_state = ST_CS;
                    end else if (c == OPT_TTYPE) begin
                        n_state = ST_TTYPE;
                    end else if (c == TN_IAC) begin
                        n_state = ST_SB_IAC;
                    end else if (c == OPT_GMCP) begin
                        n_state = ST_GMCP;
                    end else begin
                        n_state = ST_SB_SKIP;
                    end
                end
                ST_SB_SKIP: begin
                    if (c == TN_IAC) begin
                        n_state = ST_SB_IAC;
                    end
                end
                ST_SB_IAC: begin
                    n_state = ST_NORMAL;
                end
                ST_GMCP: begin
                    if (c == TN_IAC) begin
                        n_state = ST_GMCP_IAC;
                    end else begin
                        b.valid = 1'b1;
                        b.kind  = KIND_GMCP_BYTE;
                        b.value = c;
                    end
                end
                ST_GMCP_IAC: begin
                    n_state = ST_NORMAL;
                    if (c == TN_SE) begin
                        b.valid = 1'b1;
                        b.kind  = KIND_GMCP_END;
                    end
                end
                ST_CS: begin
                    if (c == SUB_REQUEST) begin
                        n_state    = ST_CS_LIST;
                        n_have_sep = 1'b0;
                        n_tpos     = '0;
                        n_tmatch   = 1'b1;
                        n_found    = 1'b0;
                    end else begin
                        n_state = ST_NORMAL;
                    end
                end
                ST_CS_LIST: begin
                    if (c == TN_IAC) begin
                        n_state = ST_CS_IAC;
                    end else if (!r_have_sep) begin
                        n_sep      = c;
                        n_have_sep = 1'b1;
                    end else if (c == r_sep) begin
                        if (close_hit) begin
                            n_found  = 1'b1;
                            n_fspell = r_tspell;
                        end
                        n_tpos   = '0;
                        n_tmatch = 1'b1;
                    end else if (r_tpos < 3'(TOKEN_LEN) && upper == utf8_char(r_tpos)) begin
                        for (int i = 0; i < TOKEN_LEN; i++) begin
                            if (r_tpos == 3'(i)) begin
                                n_tspell[i] = c;
                            end
                        end
                        n_tpos = r_tpos + 3'd1;
                    end else begin
                        n_tmatch = 1'b0;
                    end
                end
                ST_CS_IAC: begin
                    n_state = ST_NORMAL;
                    if (c == TN_SE && r_have_sep) begin
                        if (close_hit) begin
                            n_found  = 1'b1;
                            n_fspell = r_tspell;
                        end
                        n_tpos   = '0;
                        n_tmatch = 1'b1;
                        b.valid  = r_found || close_hit;
                        b.mode   = MODE_CHARSET;
                        b.kind   = KIND_UTF8;
                        b.spell  = close_hit ? r_tspell : r_fspell;
                    end
                end
                ST_TTYPE: begin
                    if (c == SUB_SEND) begin
                        b.valid = 1'b1;
                        b.kind  = KIND_TTYPE;
                        n_state = ST_SB_SKIP;
                    end else begin
                        n_state = ST_NORMAL;
                    end
                end
                default: begin
                    n_state = ST_NORMAL;
                end
            endcase
        end
    end

    assign o_burst = '{valid: b.valid && i_take, mode: b.mode, kind: b.kind, tail: b.tail,
                       value: b.value, cmd: b.cmd, spell: b.spell};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_NORMAL;
            r_accept   <= 1'b1;
            r_naws     <= 1'b0;
            r_line     <= 1'b0;
            r_have_sep <= 1'b0;
            r_tpos     <= '0;
            r_tmatch   <= 1'b1;
            r_found    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_accept <= i_cfg_data;
            end
            if (i_take) begin
                r_state    <= n_state;
                r_naws     <= n_naws;
                r_line     <= n_line;
                r_have_sep <= n_have_sep;
                r_tpos     <= n_tpos;
                r_tmatch   <= n_tmatch;
                r_found    <= n_found;
            end
        end
    end

    // payload, defined before any read
    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_sep    <= n_sep;
            r_tspell <= n_tspell;
            r_fspell <= n_fspell;
        end
    end

    a_tpos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tpos <= 3'(TOKEN_LEN))
        else $error("token position past name length");

    a_found_needs_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && !i_restart && r_state == ST_CS_LIST && close_hit && r_have_sep
         && c == r_sep) |=> r_found)
        else $error("matched name not recorded");

endmodule

`default_nettype wire

// ===== rtl/core/tsdf_emitter.sv =====
// tsdf_emitter: output register that plays one descriptor out as result words
// depends on tsdf_pkg; fed by tsdf_parser
`timescale 1ns / 1ps
`default_nettype none

module tsdf_emitter
    import tsdf_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_burst     i_burst,
    output logic            o_in_ready,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [3:0]      o_kind,
    output logic [7:0]      o_value,
    output logic            o_last
);

    logic       r_busy;
    logic [3:0] r_idx;
    t_burst     r_burst;
    logic [3:0] last_idx;
    logic       word_done;
    t_kind      kind;

    always_comb begin
        case (r_burst.mode)
            MODE_ONE:     last_idx = 4'd0;
            MODE_REPLY:   last_idx = r_burst.tail ? 4'd3 : 4'd2;
            MODE_CHARSET: last_idx = 4'd11;
            default:      last_idx = 4'd0;
        endcase
    end

    assign o_valid    = r_busy;
    assign o_last     = (r_idx == last_idx);
    assign word_done  = r_busy && i_ready;
    assign o_in_ready = !r_busy || (i_ready && o_last);
    assign o_kind     = kind;

    always_comb begin
        kind    = KIND_REPLY;
        o_value = '0;
        case (r_burst.mode)
            MODE_ONE: begin
                kind = r_burst.kind;
                if (r_burst.kind == KIND_DATA || r_burst.kind == KIND_GMCP_BYTE) begin
                    o_value = r_burst.value;
                end
            end
            MODE_REPLY: begin
                case (r_idx)
                    4'd0:    o_value = TN_IAC;
                    4'd1:    o_value = r_burst.cmd;
                    4'd2:    o_value = r_burst.value;
                    default: kind = r_burst.kind;
                endcase
            end
            MODE_CHARSET: begin
                case (r_idx)
                    4'd0:    o_value = TN_IAC;
                    4'd1:    o_value = TN_SB;
                    4'd2:    o_value = OPT_CHARSET;
                    4'd3:    o_value = SUB_ACCEPTED;
                    4'd4:    o_value = r_burst.spell[0];
                    4'd5:    o_value = r_burst.spell[1];
                    4'd6:    o_value = r_burst.spell[2];
                    4'd7:    o_value = r_burst.spell[3];
                    4'd8:    o_value = r_burst.spell[4];
                    4'd9:    o_value = TN_IAC;
                    4'd10:   o_value = TN_SE;
                    default: kind = KIND_UTF8;
                endcase
            end
            default: kind = KIND_REPLY;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (i_burst.valid) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (word_done) begin
            if (o_last) begin
                r_busy <= 1'b0;
                r_idx  <= '0;
            end else begin
                r_idx <= r_idx + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_burst.valid) begin
            r_burst <= i_burst;
        end
    end

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx <= last_idx))
        else $error("word index past end of burst");

    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !o_last) |-> !o_in_ready)
        else $error("input taken while a burst is mid-way");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (word_done && o_last && !i_burst.valid) |=> !r_busy)
        else $error("output still valid after last word");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_burst.valid |-> o_in_ready)
        else $error("descriptor loaded over unfinished burst");

endmodule

`default_nettype wire

// ===== rtl/core/telnet_stream_deframer_top.sv =====
// Telnet stream deframer: takes one received byte per word and returns data, line,
// prompt, negotiation-reply and subnegotiation events. A plain byte stream runs at
// one word per clock while the output is not stalled. A byte that gives n events
// (3 or 4 for a negotiation reply, 12 for a charset reply) holds the single output
// register until its last word leaves, and input is accepted again in the cycle
// its last word leaves. The accept_utf8 register is written on the cfg channel.
// depends on tsdf_pkg, tsdf_parser, tsdf_emitter
`timescale 1ns / 1ps
`default_nettype none

module telnet_stream_deframer_top
    import tsdf_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // byte_in
    input  wire logic       s_axis_tuser,   // restart
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // byte_value
    output logic [3:0]      m_axis_tuser,   // event_kind
    output logic            m_axis_tlast,   // last
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic       i_cfg_data      // accept_utf8
);

    logic   take;
    t_burst burst;

    assign take        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready = 1'b1;

    tsdf_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (take),
        .i_byte     (s_axis_tdata),
        .i_restart  (s_axis_tuser),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_burst    (burst)
    );

    tsdf_emitter u_emitter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_burst    (burst),
        .o_in_ready (s_axis_tready),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_kind     (m_axis_tuser),
        .o_value    (m_axis_tdata),
        .o_last     (m_axis_tlast)
    );

endmodule

`default_nettype wire

// ===== dv/tb_telnet_stream_deframer_top.sv =====
// tb_telnet_stream_deframer_top: self-checking bench for the telnet stream deframer, sends byte
// words and checks every event word against a built-in predictor of the parser
// depends on tsdf_pkg and telnet_stream_deframer_top
`timescale 1ns / 1ps
`default_nettype none

module tb_telnet_stream_deframer_top;
    import tsdf_pkg::*;

    localparam int unsigned PHASE_WORDS   = 70;
    localparam int unsigned IDLE_LIMIT    = 2000;
    localparam int unsigned SETTLE_CYCLES = 20;
    localparam logic [7:0]  UTF8_NAME [5] = '{8'h55, 8'h54, 8'h46, 8'h2d, 8'h38};

    typedef enum logic [3:0] {
        PS_NORMAL, PS_IAC, PS_WILL, PS_DO, PS_NEG_SKIP, PS_SB, PS_SB_SKIP, PS_SB_IAC,
        PS_GMCP, PS_GMCP_IAC, PS_CS, PS_CS_LIST, PS_CS_IAC, PS_TTYPE
    } t_parse;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] value;
        logic       last;
    } t_event;

    typedef logic [7:0] t_byte_q [$];

    logic       i_clk;
    logic       i_rst_n       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;   // byte_in
    logic       s_axis_tuser  = 1'b0;    // restart
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;            // byte_value
    logic [3:0] m_axis_tuser;            // event_kind
    logic       m_axis_tlast;            // last
    logic       i_cfg_valid   = 1'b0;
    logic       o_cfg_ready;
    logic       i_cfg_data    = 1'b0;    // accept_utf8

    // predictor state
    logic       accept_utf8;
    t_parse     parse_st;
    logic       naws_done;
    logic       line_busy;
    logic [7:0] list_sep;
    logic       sep_seen;
    logic [2:0] name_pos;
    logic       name_ok;
    logic [7:0] name_seen [5];
    logic       utf8_hit;
    logic [7:0] utf8_spelling [5];

    t_event      event_q [$];
    t_event      burst [$];
    int unsigned words_taken   = 0;
    int unsigned events_seen   = 0;
    int unsigned cfg_writes    = 0;
    int unsigned data_words    = 0;
    int unsigned errors        = 0;
    int unsigned idle_cycles   = 0;
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;

    telnet_stream_deframer_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    function automatic void add_event(input t_kind kind, input logic [7:0] value);
        t_event ev;
        ev.kind  = kind;
        ev.value = value;
        ev.last  = 1'b0;
        burst.push_back(ev);
    endfunction

    function automatic void add_reply(input logic [7:0] cmd, input logic [7:0] opt);
        add_event(KIND_REPLY, TN_IAC);
        add_event(KIND_REPLY, cmd);
        add_event(KIND_REPLY, opt);
    endfunction

    function automatic void close_name();
        if (name_ok && name_pos == 3'd5 && !utf8_hit && accept_utf8) begin
            utf8_hit      = 1'b1;
            utf8_spelling = name_seen;
        end
        name_pos = 3'd0;
        name_ok  = 1'b1;
    endfunction

    // works out the events one accepted byte word causes and queues them
    function automatic void predict_word(input logic [7:0] c, input logic restart);
        logic [7:0] up;
        t_event     ev;
        burst.delete();
        if (restart) begin
            parse_st  = PS_NORMAL;
            line_busy = 1'b0;
            return;
        end
        case (parse_st)
            PS_NORMAL: begin
                if (c == TN_IAC) begin
                    parse_st = PS_IAC;
                end else if (c == CH_LF) begin
                    add_event(KIND_LINE_END, 8'h00);
                    line_busy = 1'b0;
                end else if (c != CH_NUL && c != CH_CR) begin
                    add_event(KIND_DATA, c);
                    line_busy = 1'b1;
                end
            end
            PS_IAC: begin
                parse_st = PS_NORMAL;
                if (c == TN_GA || c == TN_EOR) begin
                    if (line_busy) add_event(KIND_PROMPT, 8'h00);
                end else if (c == TN_DONT || c == TN_WONT) begin
                    parse_st = PS_NEG_SKIP;
                end else if (c == TN_DO) begin
                    parse_st = PS_DO;
                end else if (c == TN_WILL) begin
                    parse_st = PS_WILL;
                end else if (c == TN_IAC) begin
                    add_event(KIND_DATA, TN_IAC);
                    line_busy = 1'b1;
                end else if (c == TN_SB) begin
                    parse_st = PS_SB;
                end
            end
            PS_WILL: begin
                parse_st = PS_NORMAL;
                if (c == OPT_BINARY || c == OPT_CHARSET || c == OPT_EOR) begin
                    add_reply(TN_DO, c);
                end else if (c == OPT_SGA) begin
                    add_reply(TN_DONT, OPT_SGA);
                end else if (c == OPT_GMCP) begin
                    add_reply(TN_DO, OPT_GMCP);
                    add_event(KIND_GMCP_HELLO, 8'h00);
                end
            end
            PS_DO: begin
                parse_st = PS_NORMAL;
                if (c == OPT_BINARY || c == OPT_CHARSET || c == OPT_TTYPE) begin
                    add_reply(TN_WILL, c);
                end else if (c == OPT_NAWS) begin
                    if (!naws_done) begin
                        naws_done = 1'b1;
                        add_reply(TN_WILL, OPT_NAWS);
                        add_event(KIND_NAWS, 8'h00);
                    end
                end else begin
                    add_reply(TN_WONT, c);
                end
            end
            PS_SB: begin
                if (c == OPT_CHARSET) parse_st = PS_CS;
                else if (c == OPT_TTYPE) parse_st = PS_TTYPE;
                else if (c == TN_IAC) parse_st = PS_SB_IAC;
                else if (c == OPT_GMCP) parse_st = PS_GMCP;
                else parse_st = PS_SB_SKIP;
            end
            PS_SB_SKIP: begin
                if (c == TN_IAC) parse_st = PS_SB_IAC;
            end
            PS_GMCP: begin
                if (c == TN_IAC) parse_st = PS_GMCP_IAC;
                else add_event(KIND_GMCP_BYTE, c);
            end
            PS_GMCP_IAC: begin
                if (c == TN_SE) add_event(KIND_GMCP_END, 8'h00);
                parse_st = PS_NORMAL;
            end
            PS_CS: begin
                if (c == SUB_REQUEST) begin
                    parse_st = PS_CS_LIST;
                    sep_seen = 1'b0;
                    name_pos = 3'd0;
                    name_ok  = 1'b1;
                    utf8_hit = 1'b0;
                end else begin
                    parse_st = PS_NORMAL;
                end
            end
            PS_CS_LIST: begin
                if (c == TN_IAC) begin
                    parse_st = PS_CS_IAC;
                end else if (!sep_seen) begin
                    list_sep = c;
                    sep_seen = 1'b1;
                end else if (c == list_sep) begin
                    close_name();
                end else begin
                    up = (c >= 8'h61 && c <= 8'h7a) ? c - 8'd32 : c;
                    if (name_pos < 3'd5 && up == UTF8_NAME[name_pos]) begin
                        name_seen[name_pos] = c;
                        name_pos++;
                    end else begin
                        name_ok = 1'b0;
                    end
                end
            end
            PS_CS_IAC: begin
                parse_st = PS_NORMAL;
                if (c == TN_SE && sep_seen) begin
                    close_name();
                    if (utf8_hit) begin
                        add_event(KIND_REPLY, TN_IAC);
                        add_event(KIND_REPLY, TN_SB);
                        add_event(KIND_REPLY, OPT_CHARSET);
                        add_event(KIND_REPLY, SUB_ACCEPTED);
                        for (int i = 0; i < 5; i++) add_event(KIND_REPLY, utf8_spelling[i]);
                        add_event(KIND_REPLY, TN_IAC);
                        add_event(KIND_REPLY, TN_SE);
                        add_event(KIND_UTF8, 8'h00);
                    end
                end
            end
            PS_TTYPE: begin
                if (c == SUB_SEND) begin
                    add_event(KIND_TTYPE, 8'h00);
                    parse_st = PS_SB_SKIP;
                end else begin
                    parse_st = PS_NORMAL;
                end
            end
            default: parse_st = PS_NORMAL;
        endcase
        foreach (burst[i]) begin
            ev      = burst[i];
            ev.last = (i == burst.size() - 1);
            event_q.push_back(ev);
        end
    endfunction

    // monitor, checker and watchdog, all sampled at the rising edge
    always @(posedge i_clk) begin
        t_event want;
        logic   moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                accept_utf8 = i_cfg_data;
                cfg_writes++;
                moved = 1'b1;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                predict_word(s_axis_tdata, s_axis_tuser);
                words_taken++;
                moved = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                events_seen++;
                moved = 1'b1;
                if (event_q.size() == 0) begin
                    $error("unexpected event word: kind %0d value %0d last %0d",
                           m_axis_tuser, m_axis_tdata, m_axis_tlast);
                    errors++;
                end else begin
                    want = event_q.pop_front();
                    if (m_axis_tuser !== want.kind) begin
                        $error("event_kind mismatch: expected %0d, got %0d",
                               want.kind, m_axis_tuser);
                        errors++;
                    end
                    if (m_axis_tdata !== want.value) begin
                        $error("byte_value mismatch: expected %0d, got %0d",
                               want.value, m_axis_tdata);
                        errors++;
                    end
                    if (m_axis_tlast !== want.last) begin
                        $error("last mismatch: expected %0d, got %0d",
                               want.last, m_axis_tlast);
                        errors++;
                    end
                end
            end
            if (moved) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("FAILURE");
                    $finish;
                end
            end
        end
    end

    task automatic send_word(input logic [7:0] b, input logic restart);
        int unsigned target;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        target = words_taken + 1;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= restart;
        wait (words_taken == target);
        if (!restart) data_words++;
    endtask

    task automatic send_bytes(input t_byte_q bytes);
        foreach (bytes[i]) send_word(bytes[i], 1'b0);
    endtask

    // hold the sender off until every expected event word is out and the block settles
    task automatic drain_block();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (event_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_accept(input logic value);
        int unsigned target;
        drain_block();
        target = cfg_writes + 1;
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        wait (cfg_writes == target);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] text_byte();
        case ($urandom_range(0, 9))
            0:       return CH_NUL;
            1:       return CH_CR;
            2:       return CH_LF;
            default: return 8'($urandom_range(1, 254));
        endcase
    endfunction

    function automatic logic [7:0] mixed_case(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5a && $urandom_range(0, 1) == 1) return c + 8'd32;
        return c;
    endfunction

    // charset name: the wanted one in any case, a near miss, or something else
    function automatic t_byte_q make_name();
        t_byte_q t;
        case ($urandom_range(0, 3))
            0, 1: begin
                for (int i = 0; i < 5; i++) t.push_back(mixed_case(UTF8_NAME[i]));
            end
            2: begin
                for (int i = 0; i < 5; i++) t.push_back(mixed_case(UTF8_NAME[i]));
                case ($urandom_range(0, 2))
                    0:       void'(t.pop_back());
                    1:       t.push_back(8'h38);
                    default: t[$urandom_range(0, 4)] = 8'h5f;
                endcase
            end
            default: begin
                repeat ($urandom_range(1, 6)) t.push_back(8'($urandom_range(8'h21, 8'h7e)));
            end
        endcase
        return t;
    endfunction

    function automatic t_byte_q make_sequence();
        t_byte_q     s;
        t_byte_q     tok;
        logic [7:0]  sep;
        int unsigned n;
        case ($urandom_range(0, 11))
            0, 1, 2: begin
                repeat ($urandom_range(1, 8)) s.push_back(text_byte());
            end
            3: begin
                s.push_back(TN_IAC);
                case ($urandom_range(0, 3))
                    0:       s.push_back(TN_GA);
                    1:       s.push_back(TN_EOR);
                    2:       s.push_back(TN_IAC);
                    default: s.push_back(8'($urandom_range(0, 255)));
                endcase
            end
            4: begin
                s = '{TN_IAC, TN_WILL};
                case ($urandom_range(0, 5))
                    0:       s.push_back(OPT_BINARY);
                    1:       s.push_back(OPT_SGA);
                    2:       s.push_back(OPT_EOR);
                    3:       s.push_back(OPT_CHARSET);
                    4:       s.push_back(OPT_GMCP);
                    default: s.push_back(8'($urandom_range(0, 255)));
                endcase
            end
            5: begin
                s = '{TN_IAC, TN_DO};
                case ($urandom_range(0, 4))
                    0:       s.push_back(OPT_BINARY);
                    1:       s.push_back(OPT_TTYPE);
                    2:       s.push_back(OPT_NAWS);
                    3:       s.push_back(OPT_CHARSET);
                    default: s.push_back(8'($urandom_range(0, 255)));
                endcase
            end
            6: begin
                s = '{TN_IAC, ($urandom_range(0, 1) == 1) ? TN_DONT : TN_WONT,
                      8'($urandom_range(0, 255))};
            end
            7: begin
                s = '{TN_IAC, TN_SB, OPT_GMCP};
                repeat ($urandom_range(0, 6)) s.push_back(8'($urandom_range(0, 254)));
                s.push_back(TN_IAC);
                s.push_back(($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : TN_SE);
            end
            8: begin
                s = '{TN_IAC, TN_SB, OPT_TTYPE};
                s.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : SUB_SEND);
                s.push_back(TN_IAC);
                s.push_back(TN_SE);
            end
            9, 10: begin
                s = '{TN_IAC, TN_SB, OPT_CHARSET};
                s.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 254)) : SUB_REQUEST);
                if ($urandom_range(0, 9) != 0) begin
                    case ($urandom_range(0, 3))
                        0:       sep = 8'h2c;
                        1:       sep = 8'h3b;
                        2:       sep = 8'h20;
                        default: sep = 8'($urandom_range(0, 254));
                    endcase
                    s.push_back(sep);
                    n = $urandom_range(0, 3);
                    for (int i = 0; i < n; i++) begin
                        if (i > 0) s.push_back(sep);
                        tok = make_name();
                        foreach (tok[j]) s.push_back(tok[j]);
                    end
                    if ($urandom_range(0, 4) == 0) s.push_back(sep);
                end
                s.push_back(TN_IAC);
                s.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : TN_SE);
            end
            default: begin
                if ($urandom_range(0, 1) == 1) begin
                    repeat ($urandom_range(1, 4)) s.push_back(8'($urandom_range(0, 255)));
                end else begin
                    s = '{TN_IAC, TN_SB, 8'($urandom_range(0, 255))};
                    repeat ($urandom_range(0, 4)) s.push_back(8'($urandom_range(0, 254)));
                    s.push_back(TN_IAC);
                    s.push_back(TN_SE);
                end
            end
        endcase
        return s;
    endfunction

    task automatic test_text_and_prompts();
        send_bytes('{CH_NUL, CH_CR, 8'h41, CH_LF, TN_IAC, TN_EOR, TN_IAC, TN_IAC,
                     TN_IAC, TN_GA});
        send_word(8'hff, 1'b1);
        send_bytes('{TN_IAC, TN_GA});
    endtask

    task automatic test_option_replies();
        send_bytes('{TN_IAC, TN_WILL, OPT_GMCP, TN_IAC, TN_DO, OPT_NAWS});
    endtask

    task automatic test_charset_reply();
        send_bytes('{TN_IAC, TN_SB, OPT_CHARSET, SUB_REQUEST, 8'h3b, 8'h75, 8'h54, 8'h66,
                     8'h2d, 8'h38, TN_IAC, TN_SE});
    endtask

    task automatic test_random_traffic(input logic accept, input int unsigned idle_pct,
                                       input int unsigned stall, input int unsigned count);
        int unsigned goal;
        write_accept(accept);
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        goal          = data_words + count;
        while (data_words < goal) begin
            if ($urandom_range(0, 39) == 0) send_word(8'($urandom_range(0, 255)), 1'b1);
            else send_bytes(make_sequence());
        end
    endtask

    initial begin
        accept_utf8 = 1'b1;
        parse_st    = PS_NORMAL;
        naws_done   = 1'b0;
        line_busy   = 1'b0;
        list_sep    = 8'h00;
        sep_seen    = 1'b0;
        name_pos    = 3'd0;
        name_ok     = 1'b1;
        utf8_hit    = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_accept(1'b1);
        test_text_and_prompts();
        test_option_replies();
        test_charset_reply();
        test_random_traffic(1'b1, 0, 0, PHASE_WORDS);
        test_random_traffic(1'b0, 70, 0, PHASE_WORDS);
        test_random_traffic(1'b1, 0, 70, PHASE_WORDS);
        test_random_traffic(1'b1, 15, 15, PHASE_WORDS);
        drain_block();

        $display("covered %0d byte words and %0d event words: text, prompts, option replies,",
                 words_taken, events_seen);
        $display("gmcp, ttype and charset exchanges, with utf-8 allowed and declined, under stalls");
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire
